/* rtl/tcw_pkg.sv */
// Shared types, constants and command structures for the text console writer.
package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int POS_W     = 11;
    localparam int DATA_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - DATA_W - 1;

    // Color register reset values.
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Character codes with a control meaning, and the blank.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Operation codes of a request.
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SET   = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } t_cfg_idx;

    // Start points of the address sweep.
    typedef enum logic [1:0] {
        ADDR_ZERO       = 2'd0,
        ADDR_SECOND_ROW = 2'd1,
        ADDR_LAST_ROW   = 2'd2
    } t_addr_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;    // latch the incoming request
        logic      exec;       // apply the request to cursor and screen
        logic      addr_load;  // load the sweep address
        t_addr_sel addr_sel;
        logic      fill;       // write the fill word at the sweep address
        logic      fill_zero;  // fill with zero instead of the blank
        logic      copy;       // read one cell for the scroll copy
        logic      load_out;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic scroll_req;
        logic addr_last;
    } t_dp_sts;

endpackage

/* rtl/tcw_datapath.sv */
// Datapath: request and color registers, cursor, screen memory and result register.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  t_op                  i_req_op,
    input  logic [CHAR_W-1:0]    i_req_ch,
    input  logic [COL_W-1:0]     i_req_col,
    input  logic [ROW_W-1:0]     i_req_row,
    output logic [POS_W-1:0]     o_res_pos,
    output logic [DATA_W-1:0]    o_res_data,
    output logic                 o_res_scr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = (AW > POS_W) ? AW : POS_W;

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_A = AW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] COL_MAX    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_MAX    = RW'(ROWS - 1);

    // Latched request.
    t_op               r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    // Colors, cursor and scroll flag.
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [CW-1:0]      r_cur_col;
    logic [RW-1:0]      r_cur_row;
    logic               r_scr;
    logic [CW-1:0]      n_cur_col;
    logic [RW-1:0]      n_cur_row;
    logic               n_scr;

    // Sweep address and the pending copy write.
    logic [AW-1:0] r_addr;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_addr;

    // Screen memory.
    logic [DATA_W-1:0] r_mem [CELLS];
    logic [DATA_W-1:0] r_mem_q;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // Result register.
    logic [POS_W-1:0]  r_res_pos;
    logic [DATA_W-1:0] r_res_data;
    logic              r_res_scr;

    logic              is_nl;
    logic              is_cr;
    logic              is_bs;
    logic              is_ord;
    logic              col_last;
    logic              row_last;
    logic              wrap_row;
    logic [CW-1:0]     cl_col;
    logic [RW-1:0]     cl_row;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     cl_addr;
    logic [DATA_W-1:0] blank;
    logic [PW-1:0]     pos_w;

    // Decode of the latched character and cursor position.
    assign is_nl    = (r_ch == CH_NEWLINE);
    assign is_cr    = (r_ch == CH_RETURN);
    assign is_bs    = (r_ch == CH_BACKSPACE);
    assign is_ord   = !(is_nl || is_cr || is_bs);
    assign col_last = (r_cur_col == COL_MAX);
    assign row_last = (r_cur_row == ROW_MAX);
    assign wrap_row = is_nl || (is_ord && col_last);

    // Coordinates of a read or set, clamped to the screen.
    assign cl_col = ({1'b0, r_col} >= 8'(COLUMNS)) ? COL_MAX : CW'(r_col);
    assign cl_row = (7'(r_row) >= 7'(ROWS)) ? ROW_MAX : RW'(r_row);

    assign cur_addr = AW'(r_cur_row) * COLS_A + AW'(r_cur_col);
    assign cl_addr  = AW'(cl_row) * COLS_A + AW'(cl_col);
    assign blank    = {r_bg, r_fg, CH_SPACE};

    assign o_sts.op         = r_op;
    assign o_sts.scroll_req = (r_op == OP_PUT) && row_last && wrap_row;
    assign o_sts.addr_last  = (r_addr == LAST_CELL);

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_req_op;
            r_ch  <= i_req_ch;
            r_col <= i_req_col;
            r_row <= i_req_row;
        end
    end

    // Color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FG: r_fg <= i_cfg_data;
                CFG_BG: r_bg <= i_cfg_data;
            endcase
        end
    end

    // Next cursor position and scroll flag.
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_scr     = r_scr;
        if (i_cmd.exec) begin
            n_scr = 1'b0;
            unique case (r_op)
                OP_PUT: begin
                    if (wrap_row) begin
                        n_cur_col = '0;
                        if (row_last) begin
                            n_scr = 1'b1;
                        end else begin
                            n_cur_row = r_cur_row + RW'(1);
                        end
                    end else if (is_cr) begin
                        n_cur_col = '0;
                    end else if (is_bs) begin
                        if (r_cur_col != '0) begin
                            n_cur_col = r_cur_col - CW'(1);
                        end
                    end else begin
                        n_cur_col = r_cur_col + CW'(1);
                    end
                end
                OP_READ: begin
                    n_cur_col = r_cur_col;
                end
                OP_CLEAR: begin
                    n_cur_col = '0;
                    n_cur_row = '0;
                end
                OP_SET: begin
                    n_cur_col = cl_col;
                    n_cur_row = cl_row;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_scr     <= 1'b0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_scr     <= n_scr;
        end
    end

    // Sweep address for clearing, scroll copy and bottom row blanking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            if (i_cmd.addr_load) begin
                unique case (i_cmd.addr_sel)
                    ADDR_ZERO:       r_addr <= '0;
                    ADDR_SECOND_ROW: r_addr <= COLS_A;
                    ADDR_LAST_ROW:   r_addr <= LAST_ROW_A;
                    default:         r_addr <= '0;
                endcase
            end else if (i_cmd.fill || i_cmd.copy) begin
                r_addr <= r_addr + AW'(1);
            end
            r_cp_valid <= i_cmd.copy;
        end
    end

    // The cell read for the copy is written one row higher in the following cycle.
    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_addr - COLS_A;
    end

    // Memory port selection.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = blank;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        if (i_cmd.exec && (r_op == OP_PUT) && is_ord) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {r_bg, r_fg, r_ch};
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_data = i_cmd.fill_zero ? '0 : blank;
        end else if (r_cp_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_mem_q;
        end
        if (i_cmd.exec && (r_op == OP_READ)) begin
            rd_en   = 1'b1;
            rd_addr = cl_addr;
        end else if (i_cmd.copy) begin
            rd_en = 1'b1;
        end
    end

    // Screen memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Result register, loaded with the cursor as it stands after the request.
    assign pos_w = PW'(n_cur_row) * PW'(COLUMNS) + PW'(n_cur_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res_pos  <= pos_w[POS_W-1:0];
            r_res_data <= (r_op == OP_READ) ? r_mem_q : '0;
            r_res_scr  <= n_scr;
        end
    end

    assign o_res_pos  = r_res_pos;
    assign o_res_data = r_res_data;
    assign o_res_scr  = r_res_scr;

    // The cursor never leaves the screen.
    a_cursor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_col <= COL_MAX) && (r_cur_row <= ROW_MAX))
        else $error("cursor outside the screen");

    // A fill never meets a pending copy write on the single write port.
    a_port_conflict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.fill && r_cp_valid))
        else $error("fill collides with a pending copy write");

endmodule

/* rtl/tcw_controller.sv */
// Controller: sequences requests, screen sweeps and the result handshake.
module tcw_controller
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_RDWAIT = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_FILL   = 8'b0100_0000,
        S_HOLD   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_m_tready;

    // State sequencing and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = 1'b1;
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.op == OP_READ) begin
                    n_state = S_RDWAIT;
                end else if (i_sts.op == OP_CLEAR) begin
                    o_cmd.addr_load = 1'b1;
                    o_cmd.addr_sel  = ADDR_ZERO;
                    n_state         = S_FILL;
                end else if (i_sts.scroll_req) begin
                    o_cmd.addr_load = 1'b1;
                    o_cmd.addr_sel  = ADDR_SECOND_ROW;
                    n_state         = S_SCROLL;
                end else if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_SCROLL: begin
                o_cmd.copy = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last copy write goes out while the bottom row address loads.
                o_cmd.addr_load = 1'b1;
                o_cmd.addr_sel  = ADDR_LAST_ROW;
                n_state         = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // An accepted request is executed in the very next cycle.
    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");

    // No request is taken as the screen clearing begins after reset.
    a_init_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_tready)
        else $error("request accepted during the reset clearing pass");

endmodule

/* rtl/text_console_writer_core.sv */
// Top level of the text console writer: stream ports, controller and datapath.
//
//  Channel     | Direction | Contents
//  ------------+-----------+----------------------------------------------------
//  s (request) | in        | tuser: operation; tdata: char_code, col, row
//  m (result)  | out       | tdata: cursor_pos, read_data, scrolled
//  cfg         | in        | write enable, register index, 4-bit color value
//
//  Put character, set cursor: accept, execute; read cell: accept, execute and
//  a wait for the registered read port of the screen memory.
//  Clear screen: one cell written per cycle.
//  Scroll: one cell copied or blanked per cycle.
//  After reset the screen is zeroed with s_tready low; configuration writes
//  are taken throughout.
//  One request is in work at a time; a finished result waits in the output
//  register while the next request is accepted and executed.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // char_code[7:0], col[14:8], row[19:15], zero
    input  logic [OP_W-1:0]      i_s_tuser,  // operation[1:0]
    // Result channel.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // cursor_pos[10:0], read_data[26:11],
                                             // scrolled[27], zero
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [POS_W-1:0]  res_pos;
    logic [DATA_W-1:0] res_data;
    logic              res_scr;

    tcw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_req_op   (t_op'(i_s_tuser)),
        .i_req_ch   (i_s_tdata[CHAR_W-1:0]),
        .i_req_col  (i_s_tdata[CHAR_W+COL_W-1:CHAR_W]),
        .i_req_row  (i_s_tdata[CHAR_W+COL_W+ROW_W-1:CHAR_W+COL_W]),
        .o_res_pos  (res_pos),
        .o_res_data (res_data),
        .o_res_scr  (res_scr)
    );

    // Result payload packed from the lowest bit up.
    assign o_m_tdata = {{M_PAD_W{1'b0}}, res_scr, res_data, res_pos};

endmodule
